>>> sv/sssb_pkg.sv
// ----------------------------------------------------------------------------
// sssb_pkg: shared types and constants for the stride slot shuffle buffer
// Item kinds, register indexes, register widths and reset values, FSM states.
// ----------------------------------------------------------------------------
package sssb_pkg;

  localparam int KIND_W     = 2;
  localparam int DECK_CFG_W = 6;
  localparam int STRIDE_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [KIND_W-1:0] KIND_DATA      = 2'd0;
  localparam logic [KIND_W-1:0] KIND_HEARTBEAT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SHUTDOWN  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_DECK_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE    = 2'd1;

  localparam logic [DECK_CFG_W-1:0] DECK_SIZE_RST = 6'd32;
  localparam logic [STRIDE_W-1:0]   STRIDE_RST    = 16'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SWAP,
    ST_DREL,
    ST_FSCAN,
    ST_FEMIT,
    ST_FPASS
  } state_t;

endpackage

>>> sv/stride_slot_shuffle_buffer_core.sv
// ----------------------------------------------------------------------------
// stride_slot_shuffle_buffer_core
// Reorders a message stream through a deck of slots stepped by a stride.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | contents
//  in_     | slave     | in_tvalid/in_tready  | tdata payload, tuser func
//  out_    | master    | out_tvalid/out_tready| tdata data_out, tuser kind, tlast
//  cfg_    | write     | cfg_we               | cfg_index, cfg_wdata
//
// A data item passes through the restoring remainder unit, which finds
// (pointer + stride) mod deck one bit per cycle, then through the slot
// read/write, and then through a release if a stored item was displaced.
// A flush scans all DECK_SLOTS slots, emitting each occupied one, then
// passes the flush item itself.
// in_tready is high only between items; a pending result in the output
// register stalls the sequencer until out_tready takes it.
// Reset clears all slots at once through per-slot occupancy flops.
// ----------------------------------------------------------------------------
module stride_slot_shuffle_buffer_core
  import sssb_pkg::*;
#(
  parameter int DECK_SLOTS   = 32,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // in_tdata: payload
  input  logic [((PAYLOAD_BITS+7)/8)*8-1:0]      in_tdata,
  // in_tuser: func
  input  logic [KIND_W-1:0]                      in_tuser,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // out_tdata: data_out
  output logic [((PAYLOAD_BITS+7)/8)*8-1:0]      out_tdata,
  // out_tuser: kind
  output logic [KIND_W-1:0]                      out_tuser,
  output logic                                   out_tlast,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  input  logic                                   cfg_we,
  input  logic [CFG_IDX_W-1:0]                   cfg_index,
  input  logic [CFG_DATA_W-1:0]                  cfg_wdata
);

  localparam int TD_W  = ((PAYLOAD_BITS + 7) / 8) * 8;
  localparam int PW    = (DECK_SLOTS > 1) ? $clog2(DECK_SLOTS) : 1;
  localparam int DW    = $clog2(DECK_SLOTS + 1);
  localparam int SUM_W = STRIDE_W + 1;
  localparam int CW    = $clog2(SUM_W);

  state_t state_r, state_nxt;

  logic [DECK_CFG_W-1:0]   deck_size_r;
  logic [STRIDE_W-1:0]     stride_r;
  logic [PW-1:0]           ptr_r, ptr_nxt;
  logic [DECK_SLOTS-1:0]   full_r, full_nxt;
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  logic [DW-1:0]           rem_r, rem_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [PW-1:0]           idx_r, idx_nxt;
  logic [KIND_W-1:0]       func_r, func_nxt;
  logic [PAYLOAD_BITS-1:0] payload_r, payload_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [TD_W-1:0]         out_tdata_r, out_tdata_nxt;
  logic [KIND_W-1:0]       out_tuser_r, out_tuser_nxt;
  logic                    out_tlast_r, out_tlast_nxt;

  logic [PAYLOAD_BITS-1:0] slot_mem [DECK_SLOTS];
  logic [PAYLOAD_BITS-1:0] rd_data_r;
  logic                    mem_we, mem_re;
  logic [PW-1:0]           mem_addr;

  logic [DW-1:0]           eff;
  logic [DW:0]             trial;
  logic                    out_free;
  logic                    idx_last;
  logic                    in_fire;

  // effective deck size: zero acts as one, oversize clamps to DECK_SLOTS
  always_comb begin
    if (deck_size_r == '0) begin
      eff = DW'(1);
    end else if (deck_size_r > DECK_CFG_W'(DECK_SLOTS)) begin
      eff = DW'(DECK_SLOTS);
    end else begin
      eff = DW'(deck_size_r);
    end
  end

  assign out_free = !out_valid_r || out_tready;
  assign idx_last = (idx_r == PW'(DECK_SLOTS - 1));
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign trial     = {rem_r, sum_r[SUM_W-1]};

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    full_nxt      = full_r;
    sum_nxt       = sum_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    func_nxt      = func_r;
    payload_nxt   = payload_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_tdata_nxt = out_tdata_r;
    out_tuser_nxt = out_tuser_r;
    out_tlast_nxt = out_tlast_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_addr      = ptr_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          func_nxt    = in_tuser;
          payload_nxt = in_tdata[PAYLOAD_BITS-1:0];
          if (in_tuser == KIND_HEARTBEAT || in_tuser == KIND_SHUTDOWN) begin
            idx_nxt   = '0;
            state_nxt = ST_FSCAN;
          end else begin
            sum_nxt   = SUM_W'(ptr_r) + SUM_W'(stride_r);
            rem_nxt   = '0;
            cnt_nxt   = '0;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        // one restoring step: shift in the next sum bit, subtract if it fits
        if (trial >= {1'b0, eff}) begin
          rem_nxt = DW'(trial - {1'b0, eff});
        end else begin
          rem_nxt = DW'(trial);
        end
        sum_nxt = {sum_r[SUM_W-2:0], 1'b0};
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(SUM_W - 1)) begin
          ptr_nxt   = rem_nxt[PW-1:0];
          state_nxt = ST_SWAP;
        end
      end
      ST_SWAP: begin
        // old slot contents come out on the same edge the new item is stored
        mem_we          = 1'b1;
        mem_re          = 1'b1;
        mem_addr        = ptr_r;
        full_nxt[ptr_r] = 1'b1;
        state_nxt       = full_r[ptr_r] ? ST_DREL : ST_IDLE;
      end
      ST_DREL: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_tdata_nxt = TD_W'(rd_data_r);
          out_tuser_nxt = KIND_DATA;
          out_tlast_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_FSCAN: begin
        mem_addr = idx_r;
        if (full_r[idx_r]) begin
          mem_re          = 1'b1;
          full_nxt[idx_r] = 1'b0;
          state_nxt       = ST_FEMIT;
        end else if (idx_last) begin
          state_nxt = ST_FPASS;
        end else begin
          idx_nxt = idx_r + PW'(1);
        end
      end
      ST_FEMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_tdata_nxt = TD_W'(rd_data_r);
          out_tuser_nxt = KIND_DATA;
          out_tlast_nxt = 1'b0;
          if (idx_last) begin
            state_nxt = ST_FPASS;
          end else begin
            idx_nxt   = idx_r + PW'(1);
            state_nxt = ST_FSCAN;
          end
        end
      end
      ST_FPASS: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_tdata_nxt = TD_W'(payload_r);
          out_tuser_nxt = func_r;
          out_tlast_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ptr_r       <= '0;
      full_r      <= '0;
      out_valid_r <= 1'b0;
      deck_size_r <= DECK_SIZE_RST;
      stride_r    <= STRIDE_RST;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      full_r      <= full_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_DECK_SIZE: deck_size_r <= cfg_wdata[DECK_CFG_W-1:0];
          CFG_STRIDE:    stride_r    <= cfg_wdata[STRIDE_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    sum_r       <= sum_nxt;
    rem_r       <= rem_nxt;
    cnt_r       <= cnt_nxt;
    idx_r       <= idx_nxt;
    func_r      <= func_nxt;
    payload_r   <= payload_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
    out_tlast_r <= out_tlast_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_addr] <= payload_r;
    end
    if (mem_re) begin
      rd_data_r <= slot_mem[mem_addr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

`ifndef SYNTH
  // partial remainder never reaches the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < eff))
    else $error("remainder out of range");

  // the chosen slot lies inside the effective deck
  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWAP) |-> (ptr_r < eff))
    else $error("slot pointer outside deck");

  // flush leaves every slot empty before the flush item goes out
  a_flush_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FPASS) |-> (full_r == '0))
    else $error("slot still occupied at flush pass-through");

  // the slot written in a swap is marked occupied
  a_swap_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWAP) |=> full_r[$past(ptr_r)])
    else $error("stored slot not marked occupied");
`endif

endmodule
